// ----- design/ma256_pkg.sv -----
// ----------------------------------------------------------------------------
// ma256_pkg
// Shared types and constants of the 256-bit modular arithmetic core.
// ----------------------------------------------------------------------------
package ma256_pkg;

    localparam int DigitW   = 64;
    localparam int NumLimbs = 4;
    localparam int WordW    = DigitW * NumLimbs;
    localparam int InW      = 520;
    localparam int OutW     = 264;
    localparam int CfgIdxW  = 8;

    localparam logic [7:0] BitLast = 8'd255;

    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_INV = 2'd3
    } func_t;

    typedef enum logic [7:0] {
        CFG_MOD0 = 8'd0,
        CFG_MOD1 = 8'd1,
        CFG_MOD2 = 8'd2,
        CFG_MOD3 = 8'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MSEL_AB,
        MSEL_CD,
        MSEL_DC
    } msel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MS_SUB,
        ST_MS_MY,
        ST_MS_ADD,
        ST_MS_RED,
        ST_MUL_ADD,
        ST_MUL_SHIFT,
        ST_RED_INIT,
        ST_RED_SUB,
        ST_RED_SEL,
        ST_MUL_FIN,
        ST_INV_CHECK,
        ST_HALVE_U,
        ST_XADD_U,
        ST_XSHIFT_U,
        ST_HALVE_V,
        ST_XADD_V,
        ST_XSHIFT_V,
        ST_CMP,
        ST_CMP_SEL,
        ST_VSUB,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [DigitW-1:0] x;
        logic [DigitW-1:0] y;
        logic              sub;
        logic              cin;
    } alu_req_t;

endpackage

// ----- design/ma256_digit_alu.sv -----
// ----------------------------------------------------------------------------
// ma256_digit_alu
// One-limb adder/subtractor with carry chaining across serial passes.
// ----------------------------------------------------------------------------
module ma256_digit_alu (
    input  ma256_pkg::alu_req_t          req,
    output logic [ma256_pkg::DigitW-1:0] sum,
    output logic                         cout
);

    logic [ma256_pkg::DigitW-1:0] y_eff;

    assign y_eff = req.sub ? ~req.y : req.y;
    assign {cout, sum} = {1'b0, req.x} + {1'b0, y_eff}
                         + {{ma256_pkg::DigitW{1'b0}}, req.cin};

endmodule

// ----- design/modular_arith_256_core.sv -----
// ----------------------------------------------------------------------------
// modular_arith_256_core
// 256-bit modular add, subtract, multiply and inverse, one 64-bit limb a cycle.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*   : write modulus limbs (index 0..3) while the core is idle; other
//             indexes are dropped. cfg_ready is always high.
//   s_axis  : one item = func, operand a, operand b. Taken only in idle.
//   m_axis  : one item per input = result r and the no_inverse flag.
// Operations, all through one 64-bit add/subtract unit:
//   add      a + b, reduced by a conditional subtraction of the modulus
//   subtract a - b, or a + (m - b) reduced when a < b
//   multiply 256 steps of shift-and-add, then 256 steps of conditional
//            subtraction
//   inverse  per round one halving per dropped bit, a compare and a
//            modular subtract
// One item is in flight at a time. The result sits in an output register, so
// the next item is taken while the receiver stalls; a finished result waits
// until the previous one has been taken.
// Reset sets the modulus to one and empties the output.
// ----------------------------------------------------------------------------
module modular_arith_256_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ma256_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [ma256_pkg::DigitW-1:0]   cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // func, a_limb0..a_limb3, b_limb0..b_limb3, zero fill
    input  logic [ma256_pkg::InW-1:0]      s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // r_limb0..r_limb3, no_inverse, zero fill
    output logic [ma256_pkg::OutW-1:0]     m_tdata
);

    localparam int W = ma256_pkg::WordW;
    localparam int D = ma256_pkg::DigitW;

    ma256_pkg::state_t state_reg, state_next;
    ma256_pkg::msel_t  msel_reg, msel_next;
    ma256_pkg::func_t  func_reg, func_next;

    logic [2:0]   cnt_reg, cnt_next;
    logic [7:0]   bit_reg, bit_next;
    logic         carry_reg, carry_next;
    logic         addc_reg, addc_next;
    logic         noinv_reg, noinv_next;
    logic         out_valid_reg, out_valid_next;
    logic [W-1:0] mod_reg, mod_next;
    logic [W-1:0] ra_reg, ra_next, rb_reg, rb_next, rc_reg, rc_next;
    logic [W-1:0] rd_reg, rd_next, re_reg, re_next, rf_reg, rf_next;
    logic [ma256_pkg::OutW-1:0] out_data_reg, out_data_next;

    logic [W-1:0]   x_word, y_word, x_wr;
    logic [2*W-1:0] p_word, sm_word, t_word;
    logic [7:0]     lb;
    logic [8:0]     wb;
    logic           last, serial, ret_inv, out_free;
    logic           u_one, v_one, u_zero, v_zero;

    ma256_pkg::alu_req_t  alu_req;
    logic [D-1:0]         alu_sum;
    logic                 alu_cout;

    ma256_digit_alu u_alu (
        .req  (alu_req),
        .sum  (alu_sum),
        .cout (alu_cout)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ma256_pkg::ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign lb      = {cnt_reg[1:0], 6'd0};
    assign wb      = {cnt_reg, 6'd0};
    assign p_word  = {rd_reg, rc_reg};
    assign sm_word = {rb_reg, ra_reg};
    assign t_word  = {rf_reg, re_reg};
    assign ret_inv = (func_reg == ma256_pkg::FUNC_INV);
    assign out_free = !out_valid_reg || m_tready;
    assign u_one  = (ra_reg == {{(W-1){1'b0}}, 1'b1});
    assign v_one  = (rb_reg == {{(W-1){1'b0}}, 1'b1});
    assign u_zero = (ra_reg == '0);
    assign v_zero = (rb_reg == '0);

    always_comb
    begin
        unique case (msel_reg)
            ma256_pkg::MSEL_CD:
            begin
                x_word = rc_reg;
                y_word = rd_reg;
            end
            ma256_pkg::MSEL_DC:
            begin
                x_word = rd_reg;
                y_word = rc_reg;
            end
            default:
            begin
                x_word = ra_reg;
                y_word = rb_reg;
            end
        endcase
    end

    always_comb
    begin
        serial = 1'b1;
        alu_req.x   = '0;
        alu_req.y   = '0;
        alu_req.sub = 1'b0;
        unique case (state_reg)
            ma256_pkg::ST_MS_SUB:
            begin
                alu_req.x = x_word[lb +: D];
                alu_req.y = y_word[lb +: D];
                alu_req.sub = 1'b1;
            end
            ma256_pkg::ST_MS_MY:
            begin
                alu_req.x = mod_reg[lb +: D];
                alu_req.y = y_word[lb +: D];
                alu_req.sub = 1'b1;
            end
            ma256_pkg::ST_MS_ADD:
            begin
                alu_req.x = x_word[lb +: D];
                alu_req.y = re_reg[lb +: D];
            end
            ma256_pkg::ST_MS_RED:
            begin
                alu_req.x = x_word[lb +: D];
                alu_req.y = mod_reg[lb +: D];
                alu_req.sub = 1'b1;
            end
            ma256_pkg::ST_MUL_ADD:
            begin
                alu_req.x = rd_reg[lb +: D];
                alu_req.y = rb_reg[0] ? ra_reg[lb +: D] : '0;
            end
            ma256_pkg::ST_RED_SUB:
            begin
                alu_req.x = p_word[wb +: D];
                alu_req.y = sm_word[wb +: D];
                alu_req.sub = 1'b1;
            end
            ma256_pkg::ST_XADD_U:
            begin
                alu_req.x = rc_reg[lb +: D];
                alu_req.y = mod_reg[lb +: D];
            end
            ma256_pkg::ST_XADD_V:
            begin
                alu_req.x = rd_reg[lb +: D];
                alu_req.y = mod_reg[lb +: D];
            end
            ma256_pkg::ST_CMP:
            begin
                alu_req.x = ra_reg[lb +: D];
                alu_req.y = rb_reg[lb +: D];
                alu_req.sub = 1'b1;
            end
            ma256_pkg::ST_VSUB:
            begin
                alu_req.x = rb_reg[lb +: D];
                alu_req.y = ra_reg[lb +: D];
                alu_req.sub = 1'b1;
            end
            default: serial = 1'b0;
        endcase
        alu_req.cin = (cnt_reg == 3'd0) ? alu_req.sub : carry_reg;
        if (state_reg == ma256_pkg::ST_RED_SUB)
            last = (cnt_reg == 3'd7);
        else
            last = (cnt_reg[1:0] == 2'd3);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ma256_pkg::ST_IDLE:
                if (s_tvalid)
                begin
                    unique case (ma256_pkg::func_t'(s_tdata[1:0]))
                        ma256_pkg::FUNC_ADD: state_next = ma256_pkg::ST_MS_ADD;
                        ma256_pkg::FUNC_SUB: state_next = ma256_pkg::ST_MS_SUB;
                        ma256_pkg::FUNC_MUL: state_next = ma256_pkg::ST_MUL_ADD;
                        default:             state_next = ma256_pkg::ST_INV_CHECK;
                    endcase
                end
            ma256_pkg::ST_MS_SUB:
                if (last)
                begin
                    if (alu_cout)
                        state_next = ret_inv ? ma256_pkg::ST_INV_CHECK : ma256_pkg::ST_OUT;
                    else
                        state_next = ma256_pkg::ST_MS_MY;
                end
            ma256_pkg::ST_MS_MY:
                if (last) state_next = ma256_pkg::ST_MS_ADD;
            ma256_pkg::ST_MS_ADD:
                if (last) state_next = ma256_pkg::ST_MS_RED;
            ma256_pkg::ST_MS_RED:
                if (last)
                    state_next = ret_inv ? ma256_pkg::ST_INV_CHECK : ma256_pkg::ST_OUT;
            ma256_pkg::ST_MUL_ADD:
                if (last) state_next = ma256_pkg::ST_MUL_SHIFT;
            ma256_pkg::ST_MUL_SHIFT:
                state_next = (bit_reg == ma256_pkg::BitLast) ? ma256_pkg::ST_RED_INIT
                                                             : ma256_pkg::ST_MUL_ADD;
            ma256_pkg::ST_RED_INIT:
                state_next = ma256_pkg::ST_RED_SUB;
            ma256_pkg::ST_RED_SUB:
                if (last) state_next = ma256_pkg::ST_RED_SEL;
            ma256_pkg::ST_RED_SEL:
                state_next = (bit_reg == ma256_pkg::BitLast) ? ma256_pkg::ST_MUL_FIN
                                                             : ma256_pkg::ST_RED_SUB;
            ma256_pkg::ST_MUL_FIN:
                state_next = ma256_pkg::ST_OUT;
            ma256_pkg::ST_INV_CHECK:
                if (u_one || v_one || u_zero || v_zero)
                    state_next = ma256_pkg::ST_OUT;
                else
                    state_next = ma256_pkg::ST_HALVE_U;
            ma256_pkg::ST_HALVE_U:
                if (ra_reg[0])
                    state_next = ma256_pkg::ST_HALVE_V;
                else if (rc_reg[0])
                    state_next = ma256_pkg::ST_XADD_U;
            ma256_pkg::ST_XADD_U:
                if (last) state_next = ma256_pkg::ST_XSHIFT_U;
            ma256_pkg::ST_XSHIFT_U:
                state_next = ma256_pkg::ST_HALVE_U;
            ma256_pkg::ST_HALVE_V:
                if (rb_reg[0])
                    state_next = ma256_pkg::ST_CMP;
                else if (rd_reg[0])
                    state_next = ma256_pkg::ST_XADD_V;
            ma256_pkg::ST_XADD_V:
                if (last) state_next = ma256_pkg::ST_XSHIFT_V;
            ma256_pkg::ST_XSHIFT_V:
                state_next = ma256_pkg::ST_HALVE_V;
            ma256_pkg::ST_CMP:
                if (last) state_next = ma256_pkg::ST_CMP_SEL;
            ma256_pkg::ST_CMP_SEL:
                state_next = carry_reg ? ma256_pkg::ST_MS_SUB : ma256_pkg::ST_VSUB;
            ma256_pkg::ST_VSUB:
                if (last) state_next = ma256_pkg::ST_MS_SUB;
            ma256_pkg::ST_OUT:
                if (out_free) state_next = ma256_pkg::ST_IDLE;
            default:
                state_next = ma256_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next       = cnt_reg;
        bit_next       = bit_reg;
        carry_next     = carry_reg;
        addc_next      = addc_reg;
        noinv_next     = noinv_reg;
        msel_next      = msel_reg;
        func_next      = func_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mod_next       = mod_reg;
        ra_next = ra_reg;
        rb_next = rb_reg;
        rc_next = rc_reg;
        rd_next = rd_reg;
        re_next = re_reg;
        rf_next = rf_reg;
        x_wr    = x_word;

        if (m_tready)
            out_valid_next = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                ma256_pkg::CFG_MOD0: mod_next[0*D +: D] = cfg_data;
                ma256_pkg::CFG_MOD1: mod_next[1*D +: D] = cfg_data;
                ma256_pkg::CFG_MOD2: mod_next[2*D +: D] = cfg_data;
                ma256_pkg::CFG_MOD3: mod_next[3*D +: D] = cfg_data;
                default: mod_next = mod_reg;
            endcase
        end

        if (serial)
        begin
            cnt_next   = last ? 3'd0 : cnt_reg + 3'd1;
            carry_next = alu_cout;
        end

        unique case (state_reg)
            ma256_pkg::ST_IDLE:
                if (s_tvalid)
                begin
                    func_next  = ma256_pkg::func_t'(s_tdata[1:0]);
                    ra_next    = s_tdata[2 +: W];
                    rb_next    = s_tdata[2 + W +: W];
                    re_next    = s_tdata[2 + W +: W];
                    noinv_next = 1'b0;
                    msel_next  = ma256_pkg::MSEL_AB;
                    cnt_next   = 3'd0;
                    bit_next   = 8'd0;
                    rc_next    = '0;
                    rd_next    = '0;
                    if (ma256_pkg::func_t'(s_tdata[1:0]) == ma256_pkg::FUNC_INV)
                    begin
                        rb_next = mod_reg;
                        rc_next = {{(W-1){1'b0}}, 1'b1};
                    end
                end
            ma256_pkg::ST_MS_SUB:
            begin
                re_next[lb +: D] = alu_sum;
                if (last && alu_cout)
                    x_wr = re_next;
            end
            ma256_pkg::ST_MS_MY:
                re_next[lb +: D] = alu_sum;
            ma256_pkg::ST_MS_ADD:
            begin
                x_wr[lb +: D] = alu_sum;
                if (last)
                    addc_next = alu_cout;
            end
            ma256_pkg::ST_MS_RED:
            begin
                rf_next[lb +: D] = alu_sum;
                if (last && (addc_reg || alu_cout))
                    x_wr = rf_next;
            end
            ma256_pkg::ST_MUL_ADD:
                rd_next[lb +: D] = alu_sum;
            ma256_pkg::ST_MUL_SHIFT:
            begin
                {rd_next, rc_next} = {carry_reg, rd_reg, rc_reg[W-1:1]};
                rb_next  = {1'b0, rb_reg[W-1:1]};
                bit_next = bit_reg + 8'd1;
            end
            ma256_pkg::ST_RED_INIT:
            begin
                ra_next  = {mod_reg[0], {(W-1){1'b0}}};
                rb_next  = {1'b0, mod_reg[W-1:1]};
                bit_next = 8'd0;
            end
            ma256_pkg::ST_RED_SUB:
            begin
                if (cnt_reg[2])
                    rf_next[lb +: D] = alu_sum;
                else
                    re_next[lb +: D] = alu_sum;
            end
            ma256_pkg::ST_RED_SEL:
            begin
                if (carry_reg)
                    {rd_next, rc_next} = t_word;
                {rb_next, ra_next} = {1'b0, sm_word[2*W-1:1]};
                bit_next = bit_reg + 8'd1;
            end
            ma256_pkg::ST_MUL_FIN:
                ra_next = rc_reg;
            ma256_pkg::ST_INV_CHECK:
            begin
                if (u_one)
                    ra_next = rc_reg;
                else if (v_one)
                    ra_next = rd_reg;
                else if (u_zero || v_zero)
                begin
                    ra_next    = '0;
                    noinv_next = 1'b1;
                end
            end
            ma256_pkg::ST_HALVE_U:
                if (!ra_reg[0])
                begin
                    ra_next = {1'b0, ra_reg[W-1:1]};
                    if (!rc_reg[0])
                        rc_next = {1'b0, rc_reg[W-1:1]};
                end
            ma256_pkg::ST_XADD_U:
                rc_next[lb +: D] = alu_sum;
            ma256_pkg::ST_XSHIFT_U:
                rc_next = {carry_reg, rc_reg[W-1:1]};
            ma256_pkg::ST_HALVE_V:
                if (!rb_reg[0])
                begin
                    rb_next = {1'b0, rb_reg[W-1:1]};
                    if (!rd_reg[0])
                        rd_next = {1'b0, rd_reg[W-1:1]};
                end
            ma256_pkg::ST_XADD_V:
                rd_next[lb +: D] = alu_sum;
            ma256_pkg::ST_XSHIFT_V:
                rd_next = {carry_reg, rd_reg[W-1:1]};
            ma256_pkg::ST_CMP:
                re_next[lb +: D] = alu_sum;
            ma256_pkg::ST_CMP_SEL:
            begin
                if (carry_reg)
                begin
                    ra_next   = re_reg;
                    msel_next = ma256_pkg::MSEL_CD;
                end
                else
                    msel_next = ma256_pkg::MSEL_DC;
            end
            ma256_pkg::ST_VSUB:
                rb_next[lb +: D] = alu_sum;
            ma256_pkg::ST_OUT:
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(ma256_pkg::OutW-W-1){1'b0}}, noinv_reg, ra_reg};
                end
            default: ;
        endcase

        // write back the modular-subtract target
        if (state_reg == ma256_pkg::ST_MS_SUB || state_reg == ma256_pkg::ST_MS_ADD
            || state_reg == ma256_pkg::ST_MS_RED)
        begin
            unique case (msel_reg)
                ma256_pkg::MSEL_CD: rc_next = x_wr;
                ma256_pkg::MSEL_DC: rd_next = x_wr;
                default:            ra_next = x_wr;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ma256_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            mod_reg       <= {{(W-1){1'b0}}, 1'b1};
            cnt_reg       <= 3'd0;
            bit_reg       <= 8'd0;
            carry_reg     <= 1'b0;
            addc_reg      <= 1'b0;
            noinv_reg     <= 1'b0;
            msel_reg      <= ma256_pkg::MSEL_AB;
            func_reg      <= ma256_pkg::FUNC_ADD;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            mod_reg       <= mod_next;
            cnt_reg       <= cnt_next;
            bit_reg       <= bit_next;
            carry_reg     <= carry_next;
            addc_reg      <= addc_next;
            noinv_reg     <= noinv_next;
            msel_reg      <= msel_next;
            func_reg      <= func_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ra_reg       <= ra_next;
        rb_reg       <= rb_next;
        rc_reg       <= rc_next;
        rd_reg       <= rd_next;
        re_reg       <= re_next;
        rf_reg       <= rf_next;
        out_data_reg <= out_data_next;
    end

endmodule
